/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the URL decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that stays active during reset.
`define CHK_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_DIGIT = 2'd2
  } mode_t;

  // Decoded bytes caused by one input transaction.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            last;
  } run_t;

  function automatic logic is_hex(input logic [7:0] ch);
    is_hex = (ch >= 8'h30 && ch <= 8'h39) ||
             (ch >= 8'h41 && ch <= 8'h46) ||
             (ch >= 8'h61 && ch <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    if (ch[6]) begin
      hex_nibble = ch[3:0] + 4'd9;
    end else begin
      hex_nibble = ch[3:0];
    end
  endfunction

endpackage

/* rtl/upd_in_if.sv */
// ----------------------------------------------------------------------------
// upd_in_if
// Input channel of the URL decoder: one encoded byte per transaction.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/upd_out_if.sv */
// ----------------------------------------------------------------------------
// upd_out_if
// Output channel of the URL decoder: one decoded byte per transaction.
// ----------------------------------------------------------------------------
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output out_byte, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

/* rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks the escape state and builds the run of
// decoded bytes that each transaction causes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic          clk,
  input  logic          rst,
  upd_in_if.sink        in_ch,
  input  logic          full,
  output logic          push,
  output upd_pkg::run_t run
);

  upd_pkg::mode_t mode;
  upd_pkg::mode_t mode_next;
  logic [7:0]     held;
  logic [7:0]     held_next;

  logic       accept;
  logic       hex_b;
  logic [7:0] pb;
  logic       pe;
  logic       pset;
  logic [1:0] pc;
  logic [7:0] p0;
  logic [7:0] p1;
  logic       use_plain;
  logic       emit_plain;
  logic [1:0] cnt;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hex_b       = upd_pkg::is_hex(in_ch.in_byte);

  always_comb begin
    pb        = in_ch.in_byte;
    pe        = 1'b1;
    pset      = 1'b0;
    pc        = 2'd0;
    p0        = upd_pkg::CH_PERCENT;
    p1        = held;
    use_plain = 1'b1;
    mode_next = upd_pkg::MODE_NONE;
    held_next = 8'h00;

    priority if (in_ch.in_byte == upd_pkg::CH_PERCENT) begin
      pe   = in_ch.in_last;
      pset = !in_ch.in_last;
    end else if (in_ch.in_byte == upd_pkg::CH_PLUS) begin
      pb = upd_pkg::CH_SPACE;
    end else begin
      pb = in_ch.in_byte;
    end

    unique case (mode)
      upd_pkg::MODE_PCT: begin
        if (hex_b) begin
          use_plain = 1'b0;
          if (in_ch.in_last) begin
            pc = 2'd2;
            p1 = in_ch.in_byte;
          end else begin
            mode_next = upd_pkg::MODE_DIGIT;
            held_next = in_ch.in_byte;
          end
        end else begin
          pc = 2'd1;
        end
      end
      upd_pkg::MODE_DIGIT: begin
        if (hex_b) begin
          use_plain = 1'b0;
          pc        = 2'd1;
          p0        = {upd_pkg::hex_nibble(held), upd_pkg::hex_nibble(in_ch.in_byte)};
        end else begin
          pc = 2'd2;
        end
      end
      default: begin
        pc = 2'd0;
      end
    endcase

    if (use_plain && pset) begin
      mode_next = upd_pkg::MODE_PCT;
    end
    emit_plain = use_plain && pe;
    cnt        = pc + {1'b0, emit_plain};

    run.bytes    = {pb, p1, p0};
    if (emit_plain) begin
      unique case (pc)
        2'd0:    run.bytes[0] = pb;
        2'd1:    run.bytes[1] = pb;
        default: run.bytes[2] = pb;
      endcase
    end
    run.last_idx = cnt - 2'd1;
    run.last     = in_ch.in_last;
    push         = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= upd_pkg::MODE_NONE;
      held <= 8'h00;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

/* rtl/upd_fifo.sv */
// ----------------------------------------------------------------------------
// upd_fifo
// Short queue of decoded runs between the front and the back part.
// ----------------------------------------------------------------------------
module upd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::run_t wdata,
  input  logic          pop,
  output upd_pkg::run_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  upd_pkg::run_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// Takes runs from the queue and sends their bytes out one transaction each.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  upd_pkg::run_t head,
  input  logic          empty,
  output logic          pop,
  upd_out_if.source     out_ch
);

  logic [1:0] idx;
  logic       at_end;

  assign at_end = (idx == head.last_idx);

  always_comb begin
    out_ch.valid = !empty;
    unique case (idx)
      2'd0:    out_ch.out_byte = head.bytes[0];
      2'd1:    out_ch.out_byte = head.bytes[1];
      default: out_ch.out_byte = head.bytes[2];
    endcase
    out_ch.run_last   = at_end;
    out_ch.stream_end = at_end && head.last;
    pop               = out_ch.valid && out_ch.ready && at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_ch.valid && out_ch.ready) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* rtl/url_percent_decoder.sv */
// An accepted run is written to the run queue and shown once earlier runs have been sent.
// Throughput: one input byte per cycle while the queue is not full and each yields at most
// one byte; a byte that yields two or three decoded bytes holds the output side until they
// are all sent. Input ready depends only on the fill of the DEPTH-entry run queue.
// Reset (synchronous) clears the escape state, the queue and the output index.
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-urlencoded decoder: front part, run queue and back part.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);

  upd_pkg::run_t run;
  upd_pkg::run_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  upd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .run   (run)
  );

  upd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (run),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  upd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* rtl/upd_checker.sv */
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the URL decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_end
);

  logic [9:0] out_word;

  assign out_word = {out_byte, run_last, stream_end};

  `CHK_IMPLIES(a_end_is_run_last, clk, rst, out_valid && stream_end, run_last)
  `CHK_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))
  `CHK_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `CHK_NEXT_ALWAYS(a_reset_ready, clk, rst, in_ready)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .run_last   (out_ch.run_last),
  .stream_end (out_ch.stream_end)
);
